### rtl/core/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants for the sleep countdown table.
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

  localparam int unsigned THREAD_W = 8;
  localparam int unsigned MS_W     = 32;
  localparam int unsigned TICK_W   = 64;
  localparam int unsigned TPM_W    = 30;
  localparam int unsigned PROD_W   = MS_W + TPM_W;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned CMD_Q_DEPTH     = 2;
  localparam int unsigned RES_Q_DEPTH     = 4;

  localparam logic [TPM_W-1:0] TICKS_PER_MS_RST = 30'd1000000;

  typedef enum logic {
    OP_SLEEP = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_WAKE   = 2'd2,
    KIND_IDLE   = 2'd3
  } kind_t;

  // arg holds the tick product for a sleep, the elapsed ticks for a tick
  typedef struct packed {
    op_t                 op;
    logic [THREAD_W-1:0] thread;
    logic [TICK_W-1:0]   arg;
  } cmd_t;

  typedef struct packed {
    kind_t               kind;
    logic [THREAD_W-1:0] thread;
    logic                resched;
    logic                last;
  } res_t;

  typedef struct packed {
    logic [THREAD_W-1:0] thread;
    logic [TICK_W-1:0]   remaining;
  } entry_t;

endpackage

`default_nettype wire

### rtl/core/sct_fifo.sv
// ----------------------------------------------------------------------------
// sct_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/sct_front.sv
// ----------------------------------------------------------------------------
// sct_front
// Accepts requests, converts sleep lengths to ticks and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic                          in_opcode,
  input  wire logic [sct_pkg::THREAD_W-1:0]  in_thread_id,
  input  wire logic [sct_pkg::MS_W-1:0]      in_delay_ms,
  input  wire logic [sct_pkg::TICK_W-1:0]    in_tick_count,
  input  wire logic [sct_pkg::TPM_W-1:0]     ticks_per_ms,
  output logic                               cmd_valid,
  output sct_pkg::cmd_t                      cmd,
  input  wire logic                          cmd_pop
);

  import sct_pkg::*;

  logic [PROD_W-1:0]     prod;
  cmd_t                  cmd_w;
  logic [$bits(cmd_t)-1:0] cmd_q;
  logic                  cmd_empty;

  assign prod = PROD_W'(in_delay_ms) * PROD_W'(ticks_per_ms);

  always_comb begin
    cmd_w.op     = op_t'(in_opcode);
    cmd_w.thread = in_thread_id;
    cmd_w.arg    = (cmd_w.op == OP_SLEEP) ? TICK_W'(prod) : in_tick_count;
  end

  sct_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (cmd_w),
    .full  (in_full),
    .pop   (cmd_pop),
    .dout  (cmd_q),
    .empty (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;
  assign cmd       = cmd_t'(cmd_q);

endmodule

`default_nettype wire

### rtl/core/sct_back.sv
// ----------------------------------------------------------------------------
// sct_back
// Runs commands against the countdown table and queues the results.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_back #(
  parameter int unsigned TABLE_DEPTH = sct_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  input  wire sct_pkg::cmd_t  cmd,
  output logic                cmd_pop,
  output logic                res_empty,
  input  wire logic           res_pop,
  output sct_pkg::res_t       res
);

  import sct_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_S  = (AW + 1)'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PROC,
    ST_DONE
  } state_t;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] lg);
    logic [AW:0] s;
    s = (AW + 1)'(head) + (AW + 1)'(lg[AW-1:0]);
    return (s >= DEPTH_S) ? AW'(s - DEPTH_S) : s[AW-1:0];
  endfunction

  // table memory, head at logical position 0
  entry_t mem [TABLE_DEPTH];
  entry_t rdata_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       rd_r, rd_nxt;
  logic [CW-1:0]       wr_r, wr_nxt;
  logic [TICK_W-1:0]   ticks_r, ticks_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [THREAD_W-1:0] pend_thr_r, pend_thr_nxt;

  logic                  res_push, res_full;
  res_t                  res_w;
  logic [$bits(res_t)-1:0] res_q;
  logic [AW-1:0]         head_m1;
  logic                  expired;
  logic [CW-1:0]         rd_inc;

  assign head_m1 = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
  assign expired = (rdata_r.remaining <= ticks_r);
  assign rd_inc  = rd_r + 1'b1;

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    rd_nxt       = rd_r;
    wr_nxt       = wr_r;
    ticks_nxt    = ticks_r;
    pend_vld_nxt = pend_vld_r;
    pend_thr_nxt = pend_thr_r;
    cmd_pop      = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = head_m1;
    mem_raddr    = phys(head_r, rd_r);
    mem_wdata    = '{thread: cmd.thread, remaining: cmd.arg};
    res_push     = 1'b0;
    res_w        = '{kind: KIND_IDLE, thread: '0, resched: 1'b0, last: 1'b1};
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && !res_full) begin
          cmd_pop = 1'b1;
          if (cmd.op == OP_SLEEP) begin
            res_push = 1'b1;
            if (count_r == FULL_CNT) begin
              res_w.kind = KIND_REJECT;
            end else begin
              res_w.kind = KIND_ACCEPT;
              mem_we     = 1'b1;
              head_nxt   = head_m1;
              count_nxt  = count_r + 1'b1;
            end
          end else begin
            ticks_nxt    = cmd.arg;
            rd_nxt       = '0;
            wr_nxt       = '0;
            pend_vld_nxt = 1'b0;
            if (count_r == '0) begin
              res_push = 1'b1;
            end else begin
              state_nxt = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        mem_re    = 1'b1;
        state_nxt = ST_PROC;
      end
      ST_PROC: begin
        if (!(expired && pend_vld_r && res_full)) begin
          if (expired) begin
            if (pend_vld_r) begin
              res_push = 1'b1;
              res_w    = '{kind: KIND_WAKE, thread: pend_thr_r, resched: 1'b1,
                           last: 1'b0};
            end
            pend_vld_nxt = 1'b1;
            pend_thr_nxt = rdata_r.thread;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = phys(head_r, wr_r);
            mem_wdata = '{thread: rdata_r.thread,
                          remaining: rdata_r.remaining - ticks_r};
            wr_nxt    = wr_r + 1'b1;
          end
          rd_nxt    = rd_inc;
          state_nxt = (rd_inc == count_r) ? ST_DONE : ST_READ;
        end
      end
      ST_DONE: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (pend_vld_r) begin
            res_w = '{kind: KIND_WAKE, thread: pend_thr_r, resched: 1'b1,
                      last: 1'b1};
          end
          count_nxt = wr_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      head_r     <= '0;
      count_r    <= '0;
      rd_r       <= '0;
      wr_r       <= '0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      rd_r       <= rd_nxt;
      wr_r       <= wr_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
    ticks_r    <= ticks_nxt;
    pend_thr_r <= pend_thr_nxt;
  end

  sct_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_w),
    .full  (res_full),
    .pop   (res_pop),
    .dout  (res_q),
    .empty (res_empty)
  );

  assign res = res_t'(res_q);

endmodule

`default_nettype wire

### rtl/core/sleep_countdown_table.sv
// ----------------------------------------------------------------------------
// sleep_countdown_table
// Ordered table of sleeping threads with 64-bit tick countdowns.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive in_* and in_push; a word is taken when full is low.
//   opcode 0 inserts thread_id at the head with delay_ms * ticks_per_ms
//   ticks; opcode 1 subtracts tick_count from each entry and drops expired ones.
//   Result queue: a result word is on out_* while out_empty is low and is
//   taken with out_pop. A sleep gives one word (accepted or rejected); a
//   tick gives one wake word per expired entry, newest first, or one
//   no-wake word. out_last marks the final word of each request.
//   Flow: the engine writes a sleep word, or the no-wake word of a tick on
//   an empty table, into the result queue in the cycle it takes the
//   command. A sleep is handled in ST_IDLE alone; a tick steps through
//   ST_READ and ST_PROC, one read and one update per entry, then ST_DONE,
//   which gives its last word. No new command is taken until ST_IDLE.
//   cfg_we/cfg_wdata load ticks_per_ms; write only while idle.
//   Reset empties the table and both queues and loads ticks_per_ms with
//   1000000. When the receiver stalls, the result queue fills, the engine
//   waits, and in_full rises once the command queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module sleep_countdown_table #(
  parameter int unsigned TABLE_DEPTH = sct_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic                          in_opcode,
  input  wire logic [sct_pkg::THREAD_W-1:0]  in_thread_id,
  input  wire logic [sct_pkg::MS_W-1:0]      in_delay_ms,
  input  wire logic [sct_pkg::TICK_W-1:0]    in_tick_count,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [1:0]                         out_kind,
  output logic [sct_pkg::THREAD_W-1:0]       out_woken_thread,
  output logic                               out_reschedule,
  output logic                               out_last,
  input  wire logic                          cfg_we,
  input  wire logic [sct_pkg::TPM_W-1:0]     cfg_wdata
);

  import sct_pkg::*;

  logic [TPM_W-1:0] ticks_per_ms_r;
  logic             cmd_valid, cmd_pop;
  cmd_t             cmd;
  res_t             res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_ms_r <= TICKS_PER_MS_RST;
    end else if (cfg_we) begin
      ticks_per_ms_r <= cfg_wdata;
    end
  end

  sct_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_opcode     (in_opcode),
    .in_thread_id  (in_thread_id),
    .in_delay_ms   (in_delay_ms),
    .in_tick_count (in_tick_count),
    .ticks_per_ms  (ticks_per_ms_r),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  sct_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_empty (out_empty),
    .res_pop   (out_pop),
    .res       (res)
  );

  assign out_kind         = res.kind;
  assign out_woken_thread = res.thread;
  assign out_reschedule   = res.resched;
  assign out_last         = res.last;

endmodule

`default_nettype wire
